// ===== src/brs_pkg.sv =====
// shared types, codes and constants for the bounded random draw block
// no dependencies
package brs_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int WORD_W      = 32;
  localparam int OFS_W       = 11;

  localparam logic [1:0] REQ_APPEND  = 2'd0;
  localparam logic [1:0] REQ_DRAW    = 2'd1;
  localparam logic [1:0] REQ_DRAW_AT = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] range_lo;
    logic [WORD_W-1:0] range_hi;
    logic [OFS_W-1:0]  start_offset;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [OFS_W-1:0]  next_offset;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic append;
    logic start;
    logic setup;
    logic check;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } sts_t;

endpackage

// ===== src/brs_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module brs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/brs_ctrl.sv =====
// controller state machine for the bounded random draw block
// depends on brs_pkg
module brs_ctrl import brs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_type,
  output logic       req_ready,
  output cmd_t       cmd,
  input  sts_t       sts
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_PUT   = 2'd3;

  logic [1:0] state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_type == REQ_APPEND) begin
            cmd.append = 1'b1;
          end else if (req_type inside {REQ_DRAW, REQ_DRAW_AT}) begin
            cmd.start  = 1'b1;
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.done) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/brs_dp.sv =====
// datapath: word store, fill count, offsets, mask rejection and output register
// depends on brs_pkg and brs_ram
module brs_dp import brs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  function automatic logic [WORD_W-1:0] smear(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] m;
    m = v;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

  logic [OFS_W-1:0]  fill, read_offset, p, p_next;
  logic              is_int, empty, exhausted, fits, done, store_we;
  logic [WORD_W-1:0] lo, hi, gap, mask, rdata, cand, diff;
  rsp_t              res, res_next, out_q;

  brs_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (fill[ADDR_W-1:0]),
    .wdata (req.word),
    .raddr (p_next[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    store_we  = cmd.append && (fill < OFS_W'(STORE_DEPTH));
    diff      = hi - lo;
    cand      = rdata & mask;
    exhausted = (p >= fill);
    fits      = (cand <= gap);
    done      = empty || exhausted || fits;
    p_next    = p;
    if (cmd.start) begin
      p_next = (req.req_type == REQ_DRAW) ? read_offset : req.start_offset;
    end else if (cmd.check && !empty && !exhausted) begin
      p_next = p + 1'b1;
    end
    res_next.next_offset = p_next;
    res_next.value       = '0;
    if (empty) begin
      res_next.status = STAT_EMPTY;
    end else if (exhausted) begin
      res_next.status = STAT_EXHAUSTED;
    end else begin
      res_next.status = STAT_OK;
      res_next.value  = lo + cand;
    end
    sts.done     = done;
    sts.out_free = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      read_offset <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (store_we) begin
        fill <= fill + 1'b1;
      end
      if (cmd.check && done && is_int) begin
        read_offset <= p_next;
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p <= p_next;
    if (cmd.start) begin
      lo     <= req.range_lo;
      hi     <= req.range_hi;
      is_int <= (req.req_type == REQ_DRAW);
    end
    if (cmd.setup) begin
      gap   <= diff;
      mask  <= smear(diff);
      empty <= (lo >= hi);
    end
    if (cmd.check && done) begin
      res <= res_next;
    end
    if (cmd.load_out) begin
      out_q <= res;
    end
  end

  assign rsp = out_q;

endmodule

// ===== src/bounded_random_from_sequence_core.sv =====
// top level of the bounded random draw block: controller plus datapath
// depends on brs_pkg, brs_ctrl, brs_dp
//
// An append word is taken while the block is idle and adds a word to a
// 1024-entry store (dropped when the store is full); it gives no result. A
// draw word occupies the block from its acceptance through a setup step for
// the range mask, check steps and a put step that hands the result to the
// output register (the put step waits while a previous result is untaken). The
// single read port of the store feeds one word per check cycle, so the checks
// examine stored words in turn, with a last check when the store runs out; an
// empty range ends at its first check and reads nothing. The output register
// lets a draw run while the previous result waits to be taken.
module bounded_random_from_sequence_core import brs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  brs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_ready (req_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  brs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== src/brs_checker.sv =====
// port level assertions for the bounded random draw block, bound to the top
// depends on brs_pkg
module brs_checker import brs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != STAT_OK) |-> (rsp.value == '0))
    else $error("error result with nonzero value");

  a_ok_offset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == STAT_OK) |-> (rsp.next_offset != '0))
    else $error("good draw consumed no word");

  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready &&
    ((req.req_type == REQ_DRAW) || (req.req_type == REQ_DRAW_AT)) |=> !req_ready)
    else $error("input taken during a draw");

endmodule

bind bounded_random_from_sequence_core brs_checker u_chk (.*);
